>>> hw/rtl/mffd_pkg.sv
`default_nettype none

package mffd_pkg;

    localparam int C_ID_W        = 11;
    localparam int C_NUM_REGS    = 8;
    localparam int C_REG_SEL_W   = 3;
    localparam int C_CFG_IDX_W   = 4;
    localparam int C_SLOT_W      = 3;
    localparam int C_PAYLOAD_W   = 64;
    localparam int C_RAW_W       = 16;
    localparam int C_ANGLE_W     = 13;
    localparam int C_TEMP_W      = 8;
    localparam int C_MODE_W      = 2;
    localparam int C_TURN_W      = 16;
    localparam int C_QUEUE_DEPTH = 4;

    // Unwrap arithmetic
    localparam int C_HALF_TURN   = 4095;
    localparam int C_TURN_COUNTS = 8191;
    localparam int C_YAW_SHIFT   = 2730;
    localparam int C_TURN_SHIFT  = 13;
    localparam int C_EXP_W       = 31;
    localparam int C_MAG_W       = 30;
    localparam int C_QUOT_W      = 28;
    localparam int C_RECIP_W     = 31;
    localparam int C_RECIP_SHIFT = 32;
    // ceil(2^32 / 3): exact floor division by three for operands below 2^31
    localparam logic [C_RECIP_W-1:0] C_RECIP3 = 31'h5555_5556;

    localparam logic [C_SLOT_W-1:0] C_YAW_SLOT = 3'd4;
    localparam int C_BUS0_LAST  = 4;
    localparam int C_BUS1_FIRST = 5;

    typedef logic [C_ID_W-1:0] t_id;

    localparam t_id C_ID_RESET [C_NUM_REGS] = '{
        11'd513, 11'd514, 11'd515, 11'd516, 11'd517, 11'd513, 11'd514, 11'd518
    };

    typedef enum logic [C_MODE_W-1:0] {
        OFS_NONE = 2'd0,
        OFS_ADD  = 2'd1,
        OFS_SUB  = 2'd2
    } t_ofs_mode;

    typedef struct packed {
        logic                       hit;
        logic [C_SLOT_W-1:0]        slot;
        logic [C_RAW_W-1:0]         raw;
        logic signed [C_RAW_W-1:0]  speed;
        logic signed [C_RAW_W-1:0]  current;
        logic [C_TEMP_W-1:0]        temp;
        logic [C_MODE_W-1:0]        mode;
    } t_item;

endpackage

`default_nettype wire

>>> hw/rtl/mffd_front.sv
`default_nettype none

module mffd_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [mffd_pkg::C_CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mffd_pkg::C_ID_W-1:0]        i_cfg_data,
    input  wire logic                               i_bus_select,
    input  wire logic [mffd_pkg::C_ID_W-1:0]        i_frame_id,
    input  wire logic [mffd_pkg::C_PAYLOAD_W-1:0]   i_frame_payload,
    input  wire logic [mffd_pkg::C_MODE_W-1:0]      i_yaw_offset_mode,
    output mffd_pkg::t_item                         o_item
);
    import mffd_pkg::*;

    t_id                 r_id_regs [C_NUM_REGS];
    logic                hit;
    logic [C_SLOT_W-1:0] slot;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < C_NUM_REGS; i++) begin
                r_id_regs[i] <= C_ID_RESET[i];
            end
        end else if (i_cfg_valid && (i_cfg_index < C_CFG_IDX_W'(C_NUM_REGS))) begin
            r_id_regs[i_cfg_index[C_REG_SEL_W-1:0]] <= i_cfg_data;
        end
    end

    // Scan from the top so the lowest matching slot wins
    always_comb begin
        hit  = 1'b0;
        slot = '0;
        if (!i_bus_select) begin
            for (int i = C_BUS0_LAST; i >= 0; i--) begin
                if (r_id_regs[i] == i_frame_id) begin
                    hit  = 1'b1;
                    slot = C_SLOT_W'(i);
                end
            end
        end else begin
            for (int i = C_NUM_REGS - 1; i >= C_BUS1_FIRST; i--) begin
                if (r_id_regs[i] == i_frame_id) begin
                    hit  = 1'b1;
                    slot = C_SLOT_W'(i);
                end
            end
        end
    end

    always_comb begin
        o_item      = '0;
        o_item.hit  = hit;
        o_item.slot = slot;
        o_item.mode = i_yaw_offset_mode;
        if (hit) begin
            o_item.raw     = i_frame_payload[63:48];
            o_item.speed   = i_frame_payload[47:32];
            o_item.current = i_frame_payload[31:16];
            o_item.temp    = i_frame_payload[15:8];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mffd_queue.sv
`default_nettype none

module mffd_queue #(
    parameter int DEPTH = mffd_pkg::C_QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire mffd_pkg::t_item    i_item,
    output logic                    o_full,
    input  wire logic               i_pop,
    output mffd_pkg::t_item         o_item,
    output logic                    o_empty
);
    import mffd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mffd_back.sv
`default_nettype none

module mffd_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_item_valid,
    input  wire mffd_pkg::t_item                    i_item,
    output logic                                    o_pop,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_matched,
    output logic [mffd_pkg::C_SLOT_W-1:0]           o_motor_slot,
    output logic [mffd_pkg::C_ANGLE_W-1:0]          o_rotor_angle,
    output logic signed [mffd_pkg::C_RAW_W-1:0]     o_rotor_speed,
    output logic signed [mffd_pkg::C_RAW_W-1:0]     o_motor_current,
    output logic [mffd_pkg::C_TEMP_W-1:0]           o_motor_temperature,
    output logic signed [mffd_pkg::C_TURN_W-1:0]    o_yaw_turn_count
);
    import mffd_pkg::*;

    localparam logic signed [C_RAW_W:0] L_STEP_HI = (C_RAW_W + 1)'(C_HALF_TURN);
    localparam logic signed [C_RAW_W:0] L_STEP_LO = -L_STEP_HI;
    localparam logic signed [C_TURN_W-1:0] L_TURN_MAX = {1'b0, {(C_TURN_W-1){1'b1}}};
    localparam logic signed [C_TURN_W-1:0] L_TURN_MIN = {1'b1, {(C_TURN_W-1){1'b0}}};
    localparam int L_FOLD_W = C_ANGLE_W + 2;

    // Unwrap state
    logic [C_RAW_W-1:0]         r_prev_raw;
    logic signed [C_TURN_W-1:0] r_turn;

    // Stage registers
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic adv1, adv2, adv3, adv4, adv5;
    t_item r_it1, r_it2, r_it3, r_it4;
    logic signed [C_TURN_W-1:0] r_cnt1, r_cnt2, r_cnt3, r_cnt4;
    logic r_yaw1, r_yaw2, r_yaw3, r_yaw4;
    logic [C_MAG_W-1:0]   r_x2;
    logic r_neg2, r_neg3, r_neg4;
    logic [C_QUOT_W-1:0]  r_q3;
    logic [C_ANGLE_W-1:0] r_m4;

    // Output register
    logic                        r_matched;
    logic [C_SLOT_W-1:0]         r_slot;
    logic [C_ANGLE_W-1:0]        r_angle;
    logic signed [C_RAW_W-1:0]   r_speed;
    logic signed [C_RAW_W-1:0]   r_current;
    logic [C_TEMP_W-1:0]         r_temp;
    logic signed [C_TURN_W-1:0]  r_count_out;

    logic                        is_yaw;
    logic signed [C_RAW_W:0]     step;
    logic signed [C_TURN_W-1:0]  n_turn;
    logic [C_EXP_W-1:0]          cnt_ext;
    logic [C_EXP_W-1:0]          expanded;
    logic [C_EXP_W-1:0]          mag;
    logic [C_MAG_W+C_RECIP_W-1:0] prod;
    logic [L_FOLD_W-1:0]         fold1;
    logic [C_ANGLE_W:0]          fold2;
    logic [C_ANGLE_W-1:0]        rem_mod;
    logic [C_ANGLE_W-1:0]        rem_pos;
    logic [L_FOLD_W-1:0]         shifted;
    logic [C_ANGLE_W-1:0]        n_angle;

    assign adv5  = !r_v5 || !i_out_stall;
    assign adv4  = !r_v4 || adv5;
    assign adv3  = !r_v3 || adv4;
    assign adv2  = !r_v2 || adv3;
    assign adv1  = !r_v1 || adv2;
    assign o_pop = i_item_valid && adv1;

    // Stage 1: turn counter step, taken in queue order
    always_comb begin
        is_yaw = i_item.hit && (i_item.slot == C_YAW_SLOT);
        step   = $signed({1'b0, i_item.raw}) - $signed({1'b0, r_prev_raw});
        n_turn = r_turn;
        if (step > L_STEP_HI && r_turn != L_TURN_MIN) begin
            n_turn = r_turn - 1'b1;
        end else if (step < L_STEP_LO && r_turn != L_TURN_MAX) begin
            n_turn = r_turn + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw <= '0;
            r_turn     <= '0;
        end else if (o_pop && is_yaw) begin
            r_prev_raw <= i_item.raw;
            r_turn     <= n_turn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_it1  <= i_item;
            r_cnt1 <= is_yaw ? n_turn : r_turn;
            r_yaw1 <= is_yaw;
        end
    end

    // Stage 2: expanded position = raw + count * 8191, split into sign and 2*|E|
    always_comb begin
        cnt_ext  = {{(C_EXP_W-C_TURN_W){r_cnt1[C_TURN_W-1]}}, r_cnt1};
        expanded = {{(C_EXP_W-C_RAW_W){1'b0}}, r_it1.raw}
                 + (cnt_ext << C_TURN_SHIFT) - cnt_ext;
        mag      = expanded[C_EXP_W-1] ? (~expanded + 1'b1) : expanded;
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_it2  <= r_it1;
            r_cnt2 <= r_cnt1;
            r_yaw2 <= r_yaw1;
            r_neg2 <= expanded[C_EXP_W-1];
            r_x2   <= {mag[C_MAG_W-2:0], 1'b0};
        end
    end

    // Stage 3: divide by three through the reciprocal
    assign prod = {{C_RECIP_W{1'b0}}, r_x2} * {{C_MAG_W{1'b0}}, C_RECIP3};

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_it3  <= r_it2;
            r_cnt3 <= r_cnt2;
            r_yaw3 <= r_yaw2;
            r_neg3 <= r_neg2;
            r_q3   <= prod[C_RECIP_SHIFT+C_QUOT_W-1:C_RECIP_SHIFT];
        end
    end

    // Stage 4: magnitude modulo 2^13 - 1 by folding 13-bit chunks
    always_comb begin
        fold1 = L_FOLD_W'(r_q3[C_ANGLE_W-1:0])
              + L_FOLD_W'(r_q3[2*C_ANGLE_W-1:C_ANGLE_W])
              + L_FOLD_W'(r_q3[C_QUOT_W-1:2*C_ANGLE_W]);
        fold2 = (C_ANGLE_W + 1)'(fold1[C_ANGLE_W-1:0])
              + (C_ANGLE_W + 1)'(fold1[L_FOLD_W-1:C_ANGLE_W]);
        if (fold2 >= (C_ANGLE_W + 1)'(C_TURN_COUNTS)) begin
            rem_mod = C_ANGLE_W'(fold2 - (C_ANGLE_W + 1)'(C_TURN_COUNTS));
        end else begin
            rem_mod = fold2[C_ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_it4  <= r_it3;
            r_cnt4 <= r_cnt3;
            r_yaw4 <= r_yaw3;
            r_neg4 <= r_neg3;
            r_m4   <= rem_mod;
        end
    end

    // Stage 5: fold negatives, apply the offset, pick the angle
    always_comb begin
        rem_pos = (r_neg4 && r_m4 != '0) ? C_ANGLE_W'(C_TURN_COUNTS) - r_m4 : r_m4;
        shifted = L_FOLD_W'(rem_pos);
        case (r_it4.mode)
            OFS_ADD: begin
                shifted = L_FOLD_W'(rem_pos) + L_FOLD_W'(C_YAW_SHIFT);
                if (shifted > L_FOLD_W'(C_TURN_COUNTS)) begin
                    shifted = shifted - L_FOLD_W'(C_TURN_COUNTS);
                end
            end
            OFS_SUB: begin
                shifted = L_FOLD_W'(rem_pos) - L_FOLD_W'(C_YAW_SHIFT);
                if (shifted[L_FOLD_W-1]) begin
                    shifted = shifted + L_FOLD_W'(C_TURN_COUNTS);
                end
            end
            default: shifted = L_FOLD_W'(rem_pos);
        endcase
        n_angle = r_yaw4 ? shifted[C_ANGLE_W-1:0] : r_it4.raw[C_ANGLE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_item_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
            if (adv5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv5) begin
            r_matched   <= r_it4.hit;
            r_slot      <= r_it4.slot;
            r_angle     <= n_angle;
            r_speed     <= r_it4.speed;
            r_current   <= r_it4.current;
            r_temp      <= r_it4.temp;
            r_count_out <= r_cnt4;
        end
    end

    assign o_out_valid         = r_v5;
    assign o_matched           = r_matched;
    assign o_motor_slot        = r_slot;
    assign o_rotor_angle       = r_angle;
    assign o_rotor_speed       = r_speed;
    assign o_motor_current     = r_current;
    assign o_motor_temperature = r_temp;
    assign o_yaw_turn_count    = r_count_out;

endmodule

`default_nettype wire

>>> hw/rtl/motor_feedback_frame_decoder_core.sv
`default_nettype none

// Motor feedback frame decoder. Each input word is one received bus frame
// (bus select, 11-bit identifier, 8 payload bytes, yaw offset mode) and
// yields exactly one result word: match flag, motor slot (0-3 chassis,
// 4 yaw, 5 left, 6 right, 7 pitch), angle, speed, current, temperature and
// the yaw turn count. Unmatched frames come out with all fields zero except
// the turn count. Yaw frames are unwrapped into a saturating 16-bit turn
// count, scaled by 2/3 for the gear, reduced to one turn of 8191 counts and
// optionally shifted by +/-2730. The front matches the identifier against
// the ID registers of the selected bus in the cycle the word is accepted
// and drops the classified word into a small queue; the back runs a
// five-stage pipeline (turn count, expand, multiply by the reciprocal of
// three, modulo fold, offset into the output register). Sustained rate is
// one word per cycle while the output is not stalled. The input stalls
// only when the queue is full. ID registers are written through the
// configuration channel, which is always ready; write them only while idle.
module motor_feedback_frame_decoder_core #(
    parameter int QUEUE_DEPTH = mffd_pkg::C_QUEUE_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [mffd_pkg::C_CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mffd_pkg::C_ID_W-1:0]        i_cfg_data,
    // frame input
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_bus_select,
    input  wire logic [mffd_pkg::C_ID_W-1:0]        i_frame_id,
    input  wire logic [mffd_pkg::C_PAYLOAD_W-1:0]   i_frame_payload,
    input  wire logic [mffd_pkg::C_MODE_W-1:0]      i_yaw_offset_mode,
    // result output
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_matched,
    output logic [mffd_pkg::C_SLOT_W-1:0]           o_motor_slot,
    output logic [mffd_pkg::C_ANGLE_W-1:0]          o_rotor_angle,
    output logic signed [mffd_pkg::C_RAW_W-1:0]     o_rotor_speed,
    output logic signed [mffd_pkg::C_RAW_W-1:0]     o_motor_current,
    output logic [mffd_pkg::C_TEMP_W-1:0]           o_motor_temperature,
    output logic signed [mffd_pkg::C_TURN_W-1:0]    o_yaw_turn_count
);
    import mffd_pkg::*;

    t_item front_item;
    t_item queue_item;
    logic  queue_full;
    logic  queue_empty;
    logic  queue_push;
    logic  queue_pop;

    // Hold the input while the queue is full; push every accepted word.
    assign o_in_stall = queue_full;
    assign queue_push = i_in_valid && !queue_full;

    // Front: ID registers and identifier match
    mffd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_bus_select      (i_bus_select),
        .i_frame_id        (i_frame_id),
        .i_frame_payload   (i_frame_payload),
        .i_yaw_offset_mode (i_yaw_offset_mode),
        .o_item            (front_item)
    );

    // Decouple front and back so each side stalls on its own
    mffd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (queue_push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_item  (queue_item),
        .o_empty (queue_empty)
    );

    // Back: yaw unwrap pipeline and output register
    mffd_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_item_valid        (!queue_empty),
        .i_item              (queue_item),
        .o_pop               (queue_pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_matched           (o_matched),
        .o_motor_slot        (o_motor_slot),
        .o_rotor_angle       (o_rotor_angle),
        .o_rotor_speed       (o_rotor_speed),
        .o_motor_current     (o_motor_current),
        .o_motor_temperature (o_motor_temperature),
        .o_yaw_turn_count    (o_yaw_turn_count)
    );

endmodule

`default_nettype wire

>>> dv/feedback_frame_checker.sv
`timescale 1ns / 1ps

module feedback_frame_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    input  wire logic                                 i_cfg_ready,
    input  wire logic [mffd_pkg::C_CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [mffd_pkg::C_ID_W-1:0]          i_cfg_data,
    input  wire logic                                 i_in_valid,
    input  wire logic                                 i_in_stall,
    input  wire logic                                 i_bus_select,
    input  wire logic [mffd_pkg::C_ID_W-1:0]          i_frame_id,
    input  wire logic [mffd_pkg::C_PAYLOAD_W-1:0]     i_frame_payload,
    input  wire logic [mffd_pkg::C_MODE_W-1:0]        i_yaw_offset_mode,
    input  wire logic                                 i_out_valid,
    input  wire logic                                 i_out_stall,
    input  wire logic                                 i_matched,
    input  wire logic [mffd_pkg::C_SLOT_W-1:0]        i_motor_slot,
    input  wire logic [mffd_pkg::C_ANGLE_W-1:0]       i_rotor_angle,
    input  wire logic signed [mffd_pkg::C_RAW_W-1:0]  i_rotor_speed,
    input  wire logic signed [mffd_pkg::C_RAW_W-1:0]  i_motor_current,
    input  wire logic [mffd_pkg::C_TEMP_W-1:0]        i_motor_temperature,
    input  wire logic signed [mffd_pkg::C_TURN_W-1:0] i_yaw_turn_count,
    output int                                        o_pending,
    output int                                        o_fail_count
);
    import mffd_pkg::*;

    typedef struct {
        logic                       matched;
        logic [C_SLOT_W-1:0]        slot;
        logic [C_ANGLE_W-1:0]       angle;
        logic signed [C_RAW_W-1:0]  speed;
        logic signed [C_RAW_W-1:0]  current;
        logic [C_TEMP_W-1:0]        temp;
        logic signed [C_TURN_W-1:0] turns;
    } t_decoded;

    t_id                motor_ids [C_NUM_REGS];
    logic [C_RAW_W-1:0] last_yaw_raw;
    int                 yaw_turns;
    t_decoded           decoded_q [$];
    int                 mismatches = 0;

    assign o_fail_count = mismatches;

    // Match the identifier on its bus, unpack the fields, unwrap the yaw angle.
    function automatic t_decoded decode_frame(input logic bus, input t_id id,
                                              input logic [C_PAYLOAD_W-1:0] payload,
                                              input logic [C_MODE_W-1:0] mode);
        t_decoded           res;
        int                 lo;
        int                 hi;
        logic [C_RAW_W-1:0] raw;
        int                 step;
        longint             expanded;
        longint             scaled;
        int                 folded;
        res.matched = 1'b0;
        res.slot    = '0;
        res.angle   = '0;
        res.speed   = '0;
        res.current = '0;
        res.temp    = '0;
        lo = bus ? C_BUS1_FIRST : 0;
        hi = bus ? C_NUM_REGS - 1 : C_BUS0_LAST;
        for (int r = lo; r <= hi; r++) begin
            if (!res.matched && motor_ids[r] == id) begin
                res.matched = 1'b1;
                res.slot    = C_SLOT_W'(r);
            end
        end
        if (res.matched) begin
            raw         = payload[63:48];
            res.speed   = payload[47:32];
            res.current = payload[31:16];
            res.temp    = payload[15:8];
            if (res.slot == C_YAW_SLOT) begin
                step = int'(raw) - int'(last_yaw_raw);
                if (step > C_HALF_TURN && yaw_turns > -32768) begin
                    yaw_turns--;
                end
                if (step < -C_HALF_TURN && yaw_turns < 32767) begin
                    yaw_turns++;
                end
                last_yaw_raw = raw;
                expanded = longint'(raw) + longint'(yaw_turns) * C_TURN_COUNTS;
                scaled   = (expanded * 2) / 3;
                folded   = int'(scaled % C_TURN_COUNTS);
                if (folded < 0) begin
                    folded += C_TURN_COUNTS;
                end
                case (mode)
                    OFS_ADD: begin
                        // a sum of exactly one turn stays as is
                        folded += C_YAW_SHIFT;
                        if (folded > C_TURN_COUNTS) begin
                            folded -= C_TURN_COUNTS;
                        end
                    end
                    OFS_SUB: begin
                        folded -= C_YAW_SHIFT;
                        if (folded < 0) begin
                            folded += C_TURN_COUNTS;
                        end
                    end
                    default: ;
                endcase
                res.angle = folded[C_ANGLE_W-1:0];
            end else begin
                res.angle = raw[C_ANGLE_W-1:0];
            end
        end
        res.turns = yaw_turns[C_TURN_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            for (int r = 0; r < C_NUM_REGS; r++) begin
                motor_ids[r] = C_ID_RESET[r];
            end
            last_yaw_raw = '0;
            yaw_turns    = 0;
            decoded_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < C_NUM_REGS) begin
                motor_ids[i_cfg_index[C_REG_SEL_W-1:0]] = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                decoded_q.push_back(decode_frame(i_bus_select, i_frame_id, i_frame_payload,
                                                 i_yaw_offset_mode));
            end
            if (i_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    $error("result word with no frame pending");
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("matched", want.matched, i_matched);
                    check_field("motor_slot", want.slot, i_motor_slot);
                    check_field("rotor_angle", want.angle, i_rotor_angle);
                    check_field("rotor_speed", want.speed, i_rotor_speed);
                    check_field("motor_current", want.current, i_motor_current);
                    check_field("motor_temperature", want.temp, i_motor_temperature);
                    check_field("yaw_turn_count", want.turns, i_yaw_turn_count);
                end
            end
        end
        o_pending <= decoded_q.size();
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import mffd_pkg::*;

    // Register indexes on the configuration channel, in list order.
    localparam int REG_CHASSIS_1 = 0;
    localparam int REG_CHASSIS_2 = 1;
    localparam int REG_CHASSIS_3 = 2;
    localparam int REG_CHASSIS_4 = 3;
    localparam int REG_YAW       = 4;
    localparam int REG_LEFT      = 5;
    localparam int REG_RIGHT     = 6;
    localparam int REG_PITCH     = 7;

    // Offset mode three has no name in the package; it behaves as no offset.
    localparam logic [C_MODE_W-1:0] OFS_RESERVED = 2'd3;

    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 9;
    // Leave margin after the pipeline drains before touching registers.
    localparam int SETTLE_CYCLES    = 12;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int NUM_PHASES       = 4;
    // Rising and falling ramps that swing the turn count both ways.
    localparam int DOWN_RAMPS       = 2;
    localparam int UP_RAMPS         = 4;
    localparam int CYCLE_LIMIT      = 1_000_000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [C_CFG_IDX_W-1:0]     i_cfg_index = '0;
    t_id                        i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_bus_select = 1'b0;
    t_id                        i_frame_id = '0;
    logic [C_PAYLOAD_W-1:0]     i_frame_payload = '0;
    logic [C_MODE_W-1:0]        i_yaw_offset_mode = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic                       o_matched;
    logic [C_SLOT_W-1:0]        o_motor_slot;
    logic [C_ANGLE_W-1:0]       o_rotor_angle;
    logic signed [C_RAW_W-1:0]  o_rotor_speed;
    logic signed [C_RAW_W-1:0]  o_motor_current;
    logic [C_TEMP_W-1:0]        o_motor_temperature;
    logic signed [C_TURN_W-1:0] o_yaw_turn_count;

    int  pending;
    int  fail_count;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  cycle_count = 0;
    t_id id_shadow [C_NUM_REGS];
    t_id id_plan [C_NUM_REGS];

    int  phase_idle_pct [NUM_PHASES] = '{0, 46, 0, 38};
    int  phase_stall_pct [NUM_PHASES] = '{0, 0, 46, 38};

    always #CLK_HALF i_clk = ~i_clk;

    motor_feedback_frame_decoder_core uut (.*);

    feedback_frame_checker checker_i (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_bus_select        (i_bus_select),
        .i_frame_id          (i_frame_id),
        .i_frame_payload     (i_frame_payload),
        .i_yaw_offset_mode   (i_yaw_offset_mode),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_matched           (o_matched),
        .i_motor_slot        (o_motor_slot),
        .i_rotor_angle       (o_rotor_angle),
        .i_rotor_speed       (o_rotor_speed),
        .i_motor_current     (o_motor_current),
        .i_motor_temperature (o_motor_temperature),
        .i_yaw_turn_count    (o_yaw_turn_count),
        .o_pending           (pending),
        .o_fail_count        (fail_count)
    );

    // Stall the result side at random; the rate follows the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("motor_feedback_frame_decoder_core regression: fail");
            $finish;
        end
    end

    // Random 48 bits below the angle field.
    function automatic logic [C_PAYLOAD_W-1:0] with_raw(input logic [C_RAW_W-1:0] raw);
        return {raw, 16'($urandom), 32'($urandom)};
    endfunction

    // Present one frame word and hold it until the block takes it. Idle
    // cycles go in front of the word, never between valid and acceptance.
    task automatic send_frame(input logic bus, input t_id id,
                              input logic [C_PAYLOAD_W-1:0] payload,
                              input logic [C_MODE_W-1:0] mode);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_bus_select      <= bus;
        i_frame_id        <= id;
        i_frame_payload   <= payload;
        i_yaw_offset_mode <= mode;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and hold off until every result word is back, then let
    // the pipeline settle so register writes land on an idle block.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all eight identifier registers back to back from id_plan.
    task automatic load_ids();
        for (int r = 0; r < C_NUM_REGS; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= C_CFG_IDX_W'(r);
            i_cfg_data  <= id_plan[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            id_shadow[r] = id_plan[r];
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic directed_frames();
        t_id yaw_id;
        yaw_id = C_ID_RESET[REG_YAW];
        // every chassis slot, field extremes, sign bits, wide raw angle
        send_frame(1'b0, C_ID_RESET[REG_CHASSIS_1], 64'h0, OFS_NONE);
        send_frame(1'b0, C_ID_RESET[REG_CHASSIS_2], '1, OFS_ADD);
        send_frame(1'b0, C_ID_RESET[REG_CHASSIS_3], with_raw(16'h1FFF), OFS_SUB);
        send_frame(1'b0, C_ID_RESET[REG_CHASSIS_4], 64'hE000_8000_7FFF_FF00, OFS_RESERVED);
        // gimbal bus motors; pitch carries a raw angle above 13 bits
        send_frame(1'b1, C_ID_RESET[REG_LEFT], with_raw(16'h2000), OFS_NONE);
        send_frame(1'b1, C_ID_RESET[REG_RIGHT], with_raw(16'h0001), OFS_NONE);
        send_frame(1'b1, C_ID_RESET[REG_PITCH], 64'hFFFF_7FFF_8000_0000, OFS_NONE);
        // unmatched: right id on the wrong bus, and both identifier extremes
        send_frame(1'b1, C_ID_RESET[REG_CHASSIS_3], '1, OFS_ADD);
        send_frame(1'b0, C_ID_RESET[REG_PITCH], '1, OFS_NONE);
        send_frame(1'b0, 11'd0, '1, OFS_NONE);
        send_frame(1'b1, 11'd2047, '1, OFS_SUB);
        // yaw: small steps, then a raw of 8192 whose shifted angle lands on 8191
        send_frame(1'b0, yaw_id, with_raw(16'd4000), OFS_NONE);
        send_frame(1'b0, yaw_id, with_raw(16'd8000), OFS_SUB);
        send_frame(1'b0, yaw_id, with_raw(16'd8192), OFS_ADD);
        // large drop counts up; offset mode three acts as none
        send_frame(1'b0, yaw_id, with_raw(16'd0), OFS_RESERVED);
        // raw above one turn, then steps of exactly half a turn either way
        send_frame(1'b0, yaw_id, with_raw(16'hFFFF), OFS_NONE);
        send_frame(1'b0, yaw_id, with_raw(16'd61440), OFS_ADD);
        send_frame(1'b0, yaw_id, with_raw(16'hFFFF), OFS_SUB);
        send_frame(1'b0, yaw_id, with_raw(16'd0), OFS_NONE);
        // one count past half a turn, both directions
        send_frame(1'b0, yaw_id, with_raw(16'd4096), OFS_ADD);
        send_frame(1'b0, yaw_id, with_raw(16'd0), OFS_SUB);
    endtask

    // Rising ramps in steps of 4096 decrement on every step and increment
    // once on the wrap, so the count walks down below zero; falling ramps
    // then walk it back up past zero.
    task automatic ramp_sweep();
        t_id yaw_id;
        yaw_id = C_ID_RESET[REG_YAW];
        repeat (DOWN_RAMPS) begin
            for (int k = 0; k < 16; k++) begin
                send_frame(1'b0, yaw_id, with_raw(16'(k * 4096)), 2'($urandom_range(3)));
            end
        end
        repeat (UP_RAMPS) begin
            for (int k = 15; k >= 0; k--) begin
                send_frame(1'b0, yaw_id, with_raw(16'(k * 4096)), 2'($urandom_range(3)));
            end
        end
    endtask

    // Mostly frames aimed at a configured motor; the rest random id and bus.
    task automatic random_frame();
        int                 pick;
        logic               bus;
        t_id                id;
        logic [C_RAW_W-1:0] raw;
        pick = $urandom_range(C_NUM_REGS - 1);
        if ($urandom_range(99) < 75) begin
            bus = (pick >= C_BUS1_FIRST);
            id  = id_shadow[pick];
        end else begin
            bus = 1'($urandom_range(1));
            id  = C_ID_W'($urandom_range(2047));
        end
        if ($urandom_range(1) == 0) begin
            raw = C_RAW_W'($urandom_range(8191));
        end else begin
            raw = C_RAW_W'($urandom);
        end
        send_frame(bus, id, with_raw(raw), 2'($urandom_range(3)));
    endtask

    task automatic plan_ids(input int phase);
        case (phase)
            // extremes with duplicates on both buses: lowest slot must win
            0: id_plan = '{11'd0, 11'd2047, 11'd0, 11'd5, 11'd6, 11'd2047, 11'd2047, 11'd0};
            1: begin
                for (int r = 0; r < C_NUM_REGS; r++) begin
                    id_plan[r] = C_ID_W'($urandom_range(2047));
                end
            end
            2: id_plan = '{11'd1, 11'd2, 11'd3, 11'd4, 11'd2047, 11'd0, 11'd1, 11'd2047};
            default: id_plan = '{11'd10, 11'd10, 11'd10, 11'd10, 11'd0, 11'd2047, 11'd0, 11'd0};
        endcase
    endtask

    initial begin
        for (int r = 0; r < C_NUM_REGS; r++) begin
            id_shadow[r] = C_ID_RESET[r];
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_frames();
        ramp_sweep();

        // Each phase: quiesce, reprogram the identifiers, then random frames
        // under that phase's idle and stall rates.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            plan_ids(p);
            load_ids();
            send_idle_pct  = phase_idle_pct[p];
            recv_stall_pct = phase_stall_pct[p];
            repeat (RANDOM_PER_PHASE) random_frame();
        end
        drain();

        if (fail_count == 0) begin
            $display("motor_feedback_frame_decoder_core regression: pass");
        end else begin
            $display("motor_feedback_frame_decoder_core regression: fail");
        end
        $finish;
    end

endmodule
